FILE: hdl/drld_pkg.sv
package drld_pkg;

    // default width of the internal run counter
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // depth of the result queue in front of the output port
    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_FILL_W = $clog2(OUTQ_DEPTH + 1);

    // widest field that is actually assembled, in bytes
    localparam logic [3:0] FIELD_MAX_BYTES = 4'd8;

    localparam logic [7:0] HEADER_END = 8'h00;

    // item kinds
    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;

    // end-of-list reasons
    localparam logic [1:0] END_ZERO_HEADER = 2'd0;
    localparam logic [1:0] END_STREAM_BOUNDARY = 2'd1;
    localparam logic [1:0] END_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_list;
        logic       last_of_stream;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic [63:0] start_cluster;
        logic [63:0] run_span;
        logic [15:0] run_count;
        logic [1:0]  end_reason;
        logic        oversize_seen;
        logic        last_result;
    } t_result;

    // up to two results produced by one byte, in delivery order
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

FILE: hdl/drld_core.sv
module drld_core
    import drld_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_push    o_push
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET,
        PH_DONE
    } t_phase;

    t_phase                 r_phase, n_phase, e_phase;
    logic [3:0]             r_len_size, n_len_size, e_len_size;
    logic [3:0]             r_off_size, n_off_size, e_off_size;
    logic [3:0]             r_index, n_index, e_index;
    logic [63:0]            r_len_acc, n_len_acc, e_len_acc;
    logic [63:0]            r_off_acc, n_off_acc, e_off_acc;
    logic [63:0]            r_cluster, n_cluster, e_cluster;
    logic [COUNT_WIDTH-1:0] r_count, n_count, e_count;
    logic                   r_oversize, n_oversize, e_oversize;

    logic        finish;
    logic        run_fire;
    logic        sum_fire;
    logic        ended_now;
    logic [1:0]  sum_reason;
    logic [3:0]  index_inc;
    logic [7:0]  data;
    logic [2:0]  nb;
    logic [5:0]  sign_idx;
    logic        need_ext;
    logic [63:0] off_ext;
    logic [31:0] count_ext;
    t_result     run_res;
    t_result     sum_res;

    always_comb begin
        // a new list starts from the reset state
        if (i_item.first_of_list) begin
            e_phase    = PH_HEADER;
            e_len_size = '0;
            e_off_size = '0;
            e_index    = '0;
            e_len_acc  = '0;
            e_off_acc  = '0;
            e_cluster  = '0;
            e_count    = '0;
            e_oversize = 1'b0;
        end else begin
            e_phase    = r_phase;
            e_len_size = r_len_size;
            e_off_size = r_off_size;
            e_index    = r_index;
            e_len_acc  = r_len_acc;
            e_off_acc  = r_off_acc;
            e_cluster  = r_cluster;
            e_count    = r_count;
            e_oversize = r_oversize;
        end

        n_phase    = e_phase;
        n_len_size = e_len_size;
        n_off_size = e_off_size;
        n_index    = e_index;
        n_len_acc  = e_len_acc;
        n_off_acc  = e_off_acc;
        n_cluster  = e_cluster;
        n_count    = e_count;
        n_oversize = e_oversize;

        data       = i_item.data_byte;
        finish     = 1'b0;
        run_fire   = 1'b0;
        sum_fire   = 1'b0;
        ended_now  = 1'b0;
        sum_reason = END_ZERO_HEADER;
        index_inc  = e_index + 4'd1;

        unique case (e_phase)
            PH_HEADER: begin
                if (data == HEADER_END) begin
                    sum_fire   = 1'b1;
                    sum_reason = END_ZERO_HEADER;
                    n_phase    = PH_DONE;
                    ended_now  = 1'b1;
                end else begin
                    n_len_size = data[3:0];
                    n_off_size = data[7:4];
                    if (n_len_size > FIELD_MAX_BYTES || n_off_size > FIELD_MAX_BYTES) begin
                        n_oversize = 1'b1;
                    end
                    n_index   = '0;
                    n_len_acc = '0;
                    n_off_acc = '0;
                    if (n_len_size != 4'd0) begin
                        n_phase = PH_LENGTH;
                    end else if (n_off_size != 4'd0) begin
                        n_phase = PH_OFFSET;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_LENGTH: begin
                // bytes beyond the eighth are dropped
                if (!e_index[3]) begin
                    n_len_acc = e_len_acc | (64'(data) << {e_index[2:0], 3'b000});
                end
                n_index = index_inc;
                if (index_inc >= e_len_size) begin
                    n_index = '0;
                    if (e_off_size != 4'd0) begin
                        n_phase = PH_OFFSET;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_OFFSET: begin
                if (!e_index[3]) begin
                    n_off_acc = e_off_acc | (64'(data) << {e_index[2:0], 3'b000});
                end
                n_index = index_inc;
                if (index_inc >= e_off_size) begin
                    n_index = '0;
                    finish  = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // sign extension of a one- to seven-byte offset
        nb       = n_off_size[2:0];
        need_ext = !n_off_size[3] && (n_off_size != 4'd0);
        sign_idx = {nb, 3'b000} - 6'd1;
        off_ext  = n_off_acc;
        if (need_ext && n_off_acc[sign_idx]) begin
            off_ext = n_off_acc | (~64'd0 << {nb, 3'b000});
        end

        if (finish) begin
            n_cluster = e_cluster + off_ext;
            if (e_count != '1) begin
                n_count = e_count + COUNT_WIDTH'(1);
            end
            n_phase  = PH_HEADER;
            run_fire = 1'b1;
        end

        if (i_item.last_of_stream && !ended_now && n_phase != PH_DONE) begin
            sum_fire   = 1'b1;
            sum_reason = (n_phase == PH_HEADER) ? END_STREAM_BOUNDARY : END_TRUNCATED;
            n_phase    = PH_DONE;
        end

        count_ext = 32'(n_count);

        run_res.item_kind     = KIND_RUN;
        run_res.start_cluster = n_cluster;
        run_res.run_span      = n_len_acc;
        run_res.run_count     = count_ext[15:0];
        run_res.end_reason    = END_ZERO_HEADER;
        run_res.oversize_seen = n_oversize;
        run_res.last_result   = !sum_fire;

        sum_res.item_kind     = KIND_END;
        sum_res.start_cluster = n_cluster;
        sum_res.run_span      = '0;
        sum_res.run_count     = count_ext[15:0];
        sum_res.end_reason    = sum_reason;
        sum_res.oversize_seen = n_oversize;
        sum_res.last_result   = 1'b1;

        o_push.num    = i_accept ? (2'(run_fire) + 2'(sum_fire)) : 2'd0;
        o_push.first  = run_fire ? run_res : sum_res;
        o_push.second = sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_len_size <= '0;
            r_off_size <= '0;
            r_index    <= '0;
            r_len_acc  <= '0;
            r_off_acc  <= '0;
            r_cluster  <= '0;
            r_count    <= '0;
            r_oversize <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_len_size <= n_len_size;
            r_off_size <= n_off_size;
            r_index    <= n_index;
            r_len_acc  <= n_len_acc;
            r_off_acc  <= n_off_acc;
            r_cluster  <= n_cluster;
            r_count    <= n_count;
            r_oversize <= n_oversize;
        end
    end

endmodule

FILE: hdl/drld_outq.sv
module drld_outq
    import drld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_item
);

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_head;
    logic [OUTQ_PTR_W-1:0]  r_tail;
    logic [OUTQ_FILL_W-1:0] r_fill;
    logic                   pop;

    // room for the two results a single byte can cause
    assign o_room  = (r_fill <= OUTQ_FILL_W'(OUTQ_DEPTH - 2));
    assign o_valid = (r_fill != '0);
    assign o_item  = r_mem[r_head];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_tail <= r_tail + OUTQ_PTR_W'(i_push.num);
            r_head <= r_head + OUTQ_PTR_W'(pop);
            r_fill <= r_fill + OUTQ_FILL_W'(i_push.num) - OUTQ_FILL_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_tail + OUTQ_PTR_W'(1)] <= i_push.second;
        end
    end

endmodule

FILE: hdl/data_run_list_decoder.sv
// data run list decoder
//
// input channel: i_valid / o_ready carry one byte of an encoded run list per
// transaction, with first_of_list marking the start of a new list and
// last_of_stream marking the final byte the stream allows
// output channel: o_valid / i_ready carry one result per transaction, either a
// decoded run (start cluster, length) or an end-of-list summary
// each input byte causes zero, one or two results; last_result marks the
// final result of a byte
// each result is written into the result queue when its byte is accepted
// throughput: one byte per cycle while o_ready is high; the state update
// (shift-or into an accumulator, or one 64-bit add into the running cluster)
// sits between the input port and a four-entry result queue
// o_ready falls while the queue has fewer than two free entries, so a stalled
// receiver holds the input side back without losing a result
// reset (synchronous, active low) clears the decoder state and empties the
// queue; the block is ready in the first cycle after reset
module data_run_list_decoder
    import drld_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_item
);

    logic  accept;
    logic  room;
    t_push push;

    assign o_ready = room;
    assign accept  = i_valid && room;

    // header / length / offset decode and cluster accumulation
    drld_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_item),
        .o_push  (push)
    );

    // result queue decouples bursts of two results from a stalling receiver
    drld_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

endmodule

FILE: test/drld_result_check.sv
module drld_result_check
    import drld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_result  i_out_item,
    output int       o_errors,
    output int       o_outstanding,
    output int       o_bytes,
    output int       o_runs,
    output int       o_ends,
    output logic     o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    // runs carry no end reason
    localparam logic [1:0] RUN_NO_REASON = 2'd0;

    typedef enum logic [1:0] {
        WALK_HEADER,
        WALK_LENGTH,
        WALK_OFFSET,
        WALK_ENDED
    } t_walk;

    t_walk                      walk;
    logic [3:0]                 len_bytes;
    logic [3:0]                 off_bytes;
    logic [3:0]                 field_pos;
    logic [63:0]                length_sum;
    logic [63:0]                offset_sum;
    logic [63:0]                cluster_pos;
    logic [COUNT_WIDTH_DEF-1:0] runs_so_far;
    logic                       size_over;

    t_result expected_results[$];
    int      errors = 0;
    int      bytes_seen = 0;
    int      runs_seen = 0;
    int      ends_seen = 0;
    logic    saturated_seen = 1'b0;

    assign o_errors = errors;
    assign o_bytes = bytes_seen;
    assign o_runs = runs_seen;
    assign o_ends = ends_seen;
    assign o_saturated = saturated_seen;

    task automatic clear_walk();
        walk = WALK_HEADER;
        len_bytes = '0;
        off_bytes = '0;
        field_pos = '0;
        length_sum = '0;
        offset_sum = '0;
        cluster_pos = '0;
        runs_so_far = '0;
        size_over = 1'b0;
    endtask

    task automatic add_result(input logic kind, input logic [63:0] start,
                              input logic [63:0] len, input logic [1:0] reason);
        t_result r;
        r.item_kind = kind;
        r.start_cluster = start;
        r.run_span = len;
        r.run_count = 16'(runs_so_far);
        r.end_reason = reason;
        r.oversize_seen = size_over;
        r.last_result = 1'b0;
        expected_results.push_back(r);
    endtask

    // sign-extend the offset from its stored width and step the cluster
    task automatic close_run();
        logic [3:0]  nb;
        logic [63:0] off;
        nb = (off_bytes > FIELD_MAX_BYTES) ? FIELD_MAX_BYTES : off_bytes;
        off = offset_sum;
        if (nb != 0 && nb < FIELD_MAX_BYTES && off[nb * 8 - 1])
            off = off | (~64'd0 << (nb * 8));
        cluster_pos = cluster_pos + off;
        if (runs_so_far != '1)
            runs_so_far = runs_so_far + COUNT_WIDTH_DEF'(1);
        add_result(KIND_RUN, cluster_pos, length_sum, RUN_NO_REASON);
        walk = WALK_HEADER;
    endtask

    task automatic take_byte(input t_in_item it);
        logic [7:0] b;
        logic       ended_now;
        int         first_new;
        t_result    tail;
        b = it.data_byte;
        ended_now = 1'b0;
        first_new = expected_results.size();
        if (it.first_of_list)
            clear_walk();
        case (walk)
            WALK_HEADER: begin
                if (b == HEADER_END) begin
                    add_result(KIND_END, cluster_pos, 64'd0, END_ZERO_HEADER);
                    walk = WALK_ENDED;
                    ended_now = 1'b1;
                end else begin
                    len_bytes = b[3:0];
                    off_bytes = b[7:4];
                    if (len_bytes > FIELD_MAX_BYTES || off_bytes > FIELD_MAX_BYTES)
                        size_over = 1'b1;
                    field_pos = '0;
                    length_sum = '0;
                    offset_sum = '0;
                    if (len_bytes != 0)
                        walk = WALK_LENGTH;
                    else if (off_bytes != 0)
                        walk = WALK_OFFSET;
                    else
                        close_run();
                end
            end
            WALK_LENGTH: begin
                if (field_pos < FIELD_MAX_BYTES)
                    length_sum = length_sum | (64'(b) << (field_pos * 8));
                field_pos = field_pos + 1'b1;
                if (field_pos >= len_bytes) begin
                    field_pos = '0;
                    if (off_bytes != 0)
                        walk = WALK_OFFSET;
                    else
                        close_run();
                end
            end
            WALK_OFFSET: begin
                if (field_pos < FIELD_MAX_BYTES)
                    offset_sum = offset_sum | (64'(b) << (field_pos * 8));
                field_pos = field_pos + 1'b1;
                if (field_pos >= off_bytes) begin
                    field_pos = '0;
                    close_run();
                end
            end
            default: ;
        endcase
        if (it.last_of_stream && !ended_now && walk != WALK_ENDED) begin
            add_result(KIND_END, cluster_pos, 64'd0,
                       (walk == WALK_HEADER) ? END_STREAM_BOUNDARY : END_TRUNCATED);
            walk = WALK_ENDED;
        end
        if (expected_results.size() > first_new) begin
            tail = expected_results.pop_back();
            tail.last_result = 1'b1;
            expected_results.push_back(tail);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        logic    bad;
        if (got.item_kind == KIND_RUN)
            runs_seen++;
        else
            ends_seen++;
        if (got.item_kind == KIND_END && got.run_count == '1)
            saturated_seen = 1'b1;
        if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%t: result with nothing expected: kind %0d start %h len %h count %0d",
                         $realtime, got.item_kind, got.start_cluster, got.run_span,
                         got.run_count);
        end else begin
            want = expected_results.pop_front();
            bad = (got.item_kind !== want.item_kind)
                || (got.start_cluster !== want.start_cluster)
                || (got.run_span !== want.run_span)
                || (got.run_count !== want.run_count)
                || (got.end_reason !== want.end_reason)
                || (got.oversize_seen !== want.oversize_seen)
                || (got.last_result !== want.last_result);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("%t: mismatch, expected kind %0d start %h len %h count %0d",
                             $realtime, want.item_kind, want.start_cluster,
                             want.run_span, want.run_count);
                    $display("    reason %0d oversize %0d last %0d",
                             want.end_reason, want.oversize_seen, want.last_result);
                    $display("  actual kind %0d start %h len %h count %0d",
                             got.item_kind, got.start_cluster, got.run_span,
                             got.run_count);
                    $display("    reason %0d oversize %0d last %0d",
                             got.end_reason, got.oversize_seen, got.last_result);
                end
            end
        end
    endtask

    // results are compared before the byte of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_walk();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result(i_out_item);
            if (i_in_valid && i_in_ready) begin
                take_byte(i_in_item);
                bytes_seen++;
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

FILE: test/tb_data_run_list_decoder.sv
module tb_data_run_list_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import drld_pkg::*;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_in_item in_item = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_result  out_item;

    int   errors;
    int   outstanding;
    int   bytes_seen;
    int   runs_seen;
    int   ends_seen;
    logic saturated;

    // idle percentages for the sender and the receiver, changed per phase
    int idle_pct = 0;
    int stall_pct = 0;

    // list bytes sent in the random part, trailing ignored bytes left out
    int list_items = 0;

    t_in_item list_q[$];

    data_run_list_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    // watches both channels, predicts every result and compares
    drld_result_check result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_bytes       (bytes_seen),
        .o_runs        (runs_seen),
        .o_ends        (ends_seen),
        .o_saturated   (saturated)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: a fresh stall decision every cycle, none at all when stall_pct is 0
    always @(posedge clk) begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // one input transaction: optional idle cycles, then valid held until taken
    task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
        t_in_item it;
        it.data_byte = data;
        it.first_of_list = first;
        it.last_of_stream = last;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold the sender back until every predicted result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // bytes with no result may still sit in the pipe
        repeat (4) @(posedge clk);
    endtask

    // one run descriptor: mostly small fields, some full eight-byte ones,
    // a few oversize ones whose bytes past the eighth are dropped
    task automatic add_run();
        logic [3:0] ls;
        logic [3:0] os;
        int         pick;
        t_in_item   it;
        pick = $urandom_range(99);
        ls = 4'($urandom_range(4));
        os = 4'($urandom_range(4));
        if (pick < 10)
            ls = FIELD_MAX_BYTES;
        else if (pick < 22)
            os = FIELD_MAX_BYTES;
        else if (pick < 28) begin
            if ($urandom_range(1) == 0)
                ls = 4'($urandom_range(15, 9));
            else
                os = 4'($urandom_range(15, 9));
        end
        if (ls == 0 && os == 0)
            ls = 4'd1;
        it.first_of_list = 1'b0;
        it.last_of_stream = 1'b0;
        it.data_byte = {os, ls};
        list_q.push_back(it);
        repeat (int'(ls) + int'(os)) begin
            it.data_byte = 8'($urandom);
            list_q.push_back(it);
        end
    endtask

    // a whole list with random content and a random way of ending
    task automatic send_random_list();
        int       runs;
        int       ending;
        int       cut;
        t_in_item it;
        list_q.delete();
        runs = $urandom_range(5);
        repeat (runs) add_run();
        ending = $urandom_range(99);
        if (ending < 65 || list_q.size() == 0) begin
            it.data_byte = HEADER_END;
            it.first_of_list = 1'b0;
            it.last_of_stream = ($urandom_range(7) == 0);
            list_q.push_back(it);
        end else if (ending < 82) begin
            // stream ends on the final byte of the last run
            it = list_q[list_q.size() - 1];
            it.last_of_stream = 1'b1;
            list_q[list_q.size() - 1] = it;
        end else if (ending < 95) begin
            // stream ends somewhere inside the list, usually mid-run
            cut = $urandom_range(list_q.size() - 1);
            while (list_q.size() > cut + 1)
                void'(list_q.pop_back());
            it = list_q[cut];
            it.last_of_stream = 1'b1;
            list_q[cut] = it;
        end
        // otherwise the list is abandoned and the next one restarts the walk
        it = list_q[0];
        it.first_of_list = 1'b1;
        list_q[0] = it;
        foreach (list_q[i])
            send_byte(list_q[i].data_byte, list_q[i].first_of_list,
                      list_q[i].last_of_stream);
        list_items += list_q.size();
        // a few stray bytes after the list, normally ignored
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, 1'($urandom));
        end
    endtask

    initial begin
        int phase_end;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        // one-byte length and offset, largest length byte, negative offset
        send_byte(8'h11, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        // no offset bytes: the run starts at the unchanged cluster
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        // no length bytes, largest positive one-byte offset
        send_byte(8'h10, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        // oversize length field: nine bytes consumed, the ninth ignored
        send_byte(8'h19, 1'b0, 1'b0);
        repeat (9) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        // zero header closes the list
        send_byte(HEADER_END, 1'b0, 1'b0);
        // byte after the end of the list, ignored even with last set
        send_byte(8'hA5, 1'b0, 1'b1);
        // stream runs out mid-run, the partial run is dropped
        send_byte(8'h21, 1'b1, 1'b0);
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        // zero header on the final byte: a single summary
        send_byte(HEADER_END, 1'b1, 1'b1);
        // stream ends right on a run boundary
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h03, 1'b0, 1'b1);
        // header that is both first and last
        send_byte(8'h44, 1'b1, 1'b1);
        drain();

        // random part in four idling mixes, drained between them
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            phase_end = list_items + 350;
            while (list_items < phase_end) begin
                if ($urandom_range(19) == 0) begin
                    // unstructured byte with random flags
                    send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                    list_items++;
                end else begin
                    send_random_list();
                end
            end
            drain();
        end

        // wait for every expected result, then a few cycles for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("tb_data_run_list_decoder: %0d list bytes sent, %0d runs and %0d summaries",
                 bytes_seen, runs_seen, ends_seen);
        $display("tb_data_run_list_decoder: four idling mixes, oversize and truncated runs, %s",
                 saturated ? "run count saturated" : "run count not saturated");
        if (errors == 0)
            $display("tb_data_run_list_decoder: done, clean");
        else
            $display("tb_data_run_list_decoder: done, errors");
        $finish;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #30ms;
        $display("tb_data_run_list_decoder: done, errors");
        $finish;
    end

endmodule
